// File: src/clw_pkg.sv
`timescale 1ns / 1ps

package clw_pkg;

  // Default display geometry.
  localparam int DefColumns = 20;
  localparam int DefLines   = 4;

  // Width of the byte index within one command's write script.
  localparam int IdxW = 4;

  // Number of bytes in the init script (lone nibble slot included).
  localparam int InitLen = 10;

  // Controller command bytes.
  localparam logic [7:0] CmdSetAddr  = 8'h80;
  localparam logic [7:0] CmdClear    = 8'h01;
  localparam logic [7:0] CmdFunc8    = 8'h38;
  localparam logic [7:0] AddrMask    = 8'h7F;
  localparam logic [7:0] HighNibMask = 8'hF0;

  // Reset values of the configuration registers.
  localparam logic [15:0] RstLongWait  = 16'd2000;
  localparam logic [15:0] RstShortWait = 16'd600;
  localparam logic [15:0] RstDataWait  = 16'd4;

  // Host command codes.
  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_GOTO  = 2'd1,
    CMD_CHAR  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_EIGHT_BIT  = 2'd0,
    REG_LONG_WAIT  = 2'd1,
    REG_SHORT_WAIT = 2'd2,
    REG_DATA_WAIT  = 2'd3
  } cfg_reg_e;

  // Live configuration handed to the write emitter.
  typedef struct packed {
    logic        eight_bit;
    logic [15:0] long_wait;
    logic [15:0] short_wait;
    logic [15:0] data_wait;
  } cfg_t;

  // One decoded command, ready for the emitter.
  typedef struct packed {
    cmd_e            cmd;
    logic [7:0]      ch;
    logic [7:0]      addr;
    logic [IdxW-1:0] last_idx;
  } item_t;

  // Init script in 4-bit mode; in 8-bit mode the second entry becomes 0x38
  // and the lone nibble in the first entry is skipped.
  localparam logic [7:0] InitSeq [InitLen] = '{
    8'h20, 8'h28, 8'h08, 8'h01, 8'h06, 8'h02, 8'h0F, 8'h80, 8'h01, 8'h80
  };

  // DDRAM start address of a display line.
  function automatic logic [7:0] line_base(input logic [1:0] ln);
    logic [7:0] base;
    unique case (ln)
      2'd1:    base = 8'h40;
      2'd2:    base = 8'h14;
      2'd3:    base = 8'h54;
      default: base = 8'h00;
    endcase
    return base;
  endfunction

endpackage

// File: src/clw_emitter.sv
`timescale 1ns / 1ps

module clw_emitter import clw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        item_load_i,
  input  item_t       item_i,
  output logic        take_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        register_select_o,
  output logic [7:0]  bus_byte_o,
  output logic [15:0] wait_us_o,
  output logic        last_o
);

  logic            busy_q, busy_d;
  item_t           item_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            nib_q, nib_d;

  logic            out_valid_q, out_valid_d;
  logic            rs_q;
  logic [7:0]      byte_q;
  logic [15:0]     wait_q;
  logic            last_q;

  logic            emit;
  logic            is_last;
  logic            whole;
  logic            lone;
  logic            rs_w;
  logic [7:0]      cur_byte;
  logic [15:0]     full_wait;
  logic [7:0]      w_byte;
  logic [15:0]     w_wait;

  // Pick the byte at the current script position.
  always_comb begin
    lone     = 1'b0;
    rs_w     = 1'b0;
    cur_byte = CmdSetAddr;
    unique case (item_q.cmd)
      CMD_INIT: begin
        lone     = (idx_q == '0) && !cfg_i.eight_bit;
        cur_byte = InitSeq[idx_q];
        if (idx_q == IdxW'(1) && cfg_i.eight_bit) begin
          cur_byte = CmdFunc8;
        end
      end
      CMD_GOTO: begin
        cur_byte = item_q.addr;
      end
      CMD_CHAR: begin
        if (idx_q == '0) begin
          rs_w     = 1'b1;
          cur_byte = item_q.ch;
        end else if (idx_q == IdxW'(1)) begin
          cur_byte = item_q.addr;
        end else begin
          cur_byte = CmdSetAddr;
        end
      end
      CMD_CLEAR: begin
        cur_byte = (idx_q == '0) ? CmdClear : CmdSetAddr;
      end
      default: begin
        cur_byte = CmdSetAddr;
      end
    endcase
  end

  // Wait after the byte, and the split into bus writes.
  always_comb begin
    if (rs_w) begin
      full_wait = cfg_i.data_wait;
    end else if (cur_byte <= CmdClear) begin
      full_wait = cfg_i.long_wait;
    end else begin
      full_wait = cfg_i.short_wait;
    end

    whole = cfg_i.eight_bit || lone;
    if (whole) begin
      w_byte = cur_byte;
      w_wait = lone ? 16'd0 : full_wait;
    end else if (!nib_q) begin
      w_byte = cur_byte & HighNibMask;
      w_wait = 16'd0;
    end else begin
      w_byte = {cur_byte[3:0], 4'h0};
      w_wait = full_wait;
    end
  end

  assign emit    = busy_q && (!out_valid_q || !out_stall_i);
  assign is_last = (idx_q == item_q.last_idx) && (whole || nib_q);
  assign take_o  = !busy_q || (emit && is_last);

  // Script position and busy flag.
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    nib_d  = nib_q;
    if (emit) begin
      if (whole || nib_q) begin
        idx_d = idx_q + IdxW'(1);
        nib_d = 1'b0;
      end else begin
        nib_d = 1'b1;
      end
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
    if (item_load_i) begin
      busy_d = 1'b1;
      nib_d  = 1'b0;
      idx_d  = (item_i.cmd == CMD_INIT && cfg_i.eight_bit) ? IdxW'(1) : '0;
    end
  end

  // Output beat register.
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      nib_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      nib_q       <= nib_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_load_i) begin
      item_q <= item_i;
    end
    if (emit) begin
      rs_q   <= rs_w;
      byte_q <= w_byte;
      wait_q <= w_wait;
      last_q <= is_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign register_select_o = rs_q;
  assign bus_byte_o        = byte_q;
  assign wait_us_o         = wait_q;
  assign last_o            = last_q;

  // A new command only replaces one whose last write is leaving.
  a_load_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_load_i && busy_q |-> emit && is_last)
    else $error("command loaded over an unfinished one");

  // The script position never runs past the final byte.
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q <= item_q.last_idx)
    else $error("script index beyond final byte");

  // A write that is not the final one keeps the emitter busy.
  a_busy_after_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !is_last |=> busy_q)
    else $error("emitter went idle in the middle of a command");

  // A beat with wait zero in 4-bit mode is never the final one.
  a_last_has_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !cfg_i.eight_bit && !nib_q && !lone |-> !is_last)
    else $error("high nibble flagged as final write");

endmodule

// File: src/char_lcd_cursor_writer.sv
`timescale 1ns / 1ps

// Character display bus writer for a controller of the HD44780 kind, 4-bit
// or 8-bit bus. Each accepted host command (init, goto, write character,
// clear) turns into a run of bus write beats, one per clock while the
// output is not stalled: goto 1 or 2 beats, character 1 to 6, clear 2 or 4,
// init 9 or 19. A command is decoded and the cursor updated in the cycle it
// is accepted; its beats follow once the emitter holds it. The next command is
// accepted in the same cycle the previous command's final beat is produced,
// so commands run back to back with no gap; the single output beat register
// sets the pace at one bus write per cycle unless stalled. Configuration
// writes are always ready and should only be made while no beats are pending.
module char_lcd_cursor_writer import clw_pkg::*; #(
  parameter int COLUMNS = DefColumns,
  parameter int LINES   = DefLines
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [4:0]  column_i,
  input  logic [1:0]  line_i,
  input  logic [7:0]  character_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        register_select_o,
  output logic [7:0]  bus_byte_o,
  output logic [15:0] wait_us_o,
  output logic        last_o
);

  localparam logic [4:0] MaxCol   = 5'(COLUMNS - 1);
  localparam logic [1:0] MaxLine  = 2'(LINES - 1);
  localparam logic [5:0] ColLimit = 6'(COLUMNS);
  localparam logic [2:0] LnLimit  = 3'(LINES);

  cfg_t       cfg_q;
  logic [4:0] col_q, col_d;
  logic [1:0] line_q, line_d;

  item_t      item_d;
  logic       take;
  logic       accept;

  logic [4:0] goto_col;
  logic [1:0] goto_line;
  logic [5:0] col_inc;
  logic [2:0] line_inc;
  logic       wrap;
  logic       over;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !take;
  assign accept      = in_valid_i && take;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.eight_bit  <= 1'b0;
      cfg_q.long_wait  <= RstLongWait;
      cfg_q.short_wait <= RstShortWait;
      cfg_q.data_wait  <= RstDataWait;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_EIGHT_BIT:  cfg_q.eight_bit  <= cfg_data_i[0];
        REG_LONG_WAIT:  cfg_q.long_wait  <= cfg_data_i;
        REG_SHORT_WAIT: cfg_q.short_wait <= cfg_data_i;
        REG_DATA_WAIT:  cfg_q.data_wait  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Decode the command and work out the new cursor.
  always_comb begin
    goto_col  = (column_i > MaxCol) ? MaxCol : column_i;
    goto_line = (line_i > MaxLine) ? MaxLine : line_i;
    col_inc   = {1'b0, col_q} + 6'd1;
    line_inc  = {1'b0, line_q} + 3'd1;
    wrap      = col_inc >= ColLimit;
    over      = line_inc >= LnLimit;

    item_d.cmd      = cmd_e'(command_i);
    item_d.ch       = character_i;
    item_d.addr     = CmdSetAddr;
    item_d.last_idx = '0;
    col_d           = '0;
    line_d          = '0;

    unique case (cmd_e'(command_i))
      CMD_INIT: begin
        item_d.last_idx = IdxW'(InitLen - 1);
      end
      CMD_GOTO: begin
        item_d.addr = ((line_base(goto_line) + {3'b000, goto_col}) & AddrMask)
                      | CmdSetAddr;
        col_d       = goto_col;
        line_d      = goto_line;
      end
      CMD_CHAR: begin
        if (wrap) begin
          // Column wrap: address the next line, or line zero twice when
          // running off the bottom.
          item_d.addr     = over ? CmdSetAddr
                                 : (line_base(line_inc[1:0]) | CmdSetAddr);
          item_d.last_idx = over ? IdxW'(2) : IdxW'(1);
          col_d           = '0;
          line_d          = over ? 2'd0 : line_inc[1:0];
        end else begin
          col_d  = col_inc[4:0];
          line_d = line_q;
        end
      end
      CMD_CLEAR: begin
        item_d.last_idx = IdxW'(1);
      end
      default: begin
        item_d.last_idx = '0;
      end
    endcase
  end

  // Cursor position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      line_q <= '0;
    end else if (accept) begin
      col_q  <= col_d;
      line_q <= line_d;
    end
  end

  clw_emitter u_emitter (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .item_load_i       (accept),
    .item_i            (item_d),
    .take_o            (take),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .register_select_o (register_select_o),
    .bus_byte_o        (bus_byte_o),
    .wait_us_o         (wait_us_o),
    .last_o            (last_o)
  );

  // The cursor always stays on the display.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= MaxCol && line_q <= MaxLine)
    else $error("cursor left the display area");

  // Init and clear send the cursor home.
  a_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (command_i == CMD_INIT || command_i == CMD_CLEAR)
    |=> col_q == '0 && line_q == '0)
    else $error("cursor not at home after init or clear");

  // A character write without wrap moves one column right on the same line.
  a_char_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && command_i == CMD_CHAR && !wrap
    |=> col_q == $past(col_q) + 5'd1 && line_q == $past(line_q))
    else $error("cursor step on character write is wrong");

endmodule

// File: tb/char_lcd_cursor_writer_tb.sv
`timescale 1ns / 1ps

module char_lcd_cursor_writer_tb import clw_pkg::*; ();

  // Display geometry under test.
  localparam int TbColumns = DefColumns;
  localparam int TbLines   = DefLines;

  // Controller command bytes not provided by the package.
  localparam logic [7:0] CmdFunc4Nib  = 8'h20;
  localparam logic [7:0] CmdFunc4     = 8'h28;
  localparam logic [7:0] CmdDispOff   = 8'h08;
  localparam logic [7:0] CmdEntryMode = 8'h06;
  localparam logic [7:0] CmdHome      = 8'h02;
  localparam logic [7:0] CmdDispOn    = 8'h0F;

  // Run length guard and the receiver's long hold-off.
  localparam int CycleLimit  = 400000;
  localparam int LongHoldLen = 300;

  // One expected controller bus write.
  typedef struct packed {
    logic        rs;
    logic [7:0]  bus_byte;
    logic [15:0] wait_us;
    logic        last;
  } bus_write_t;

  // Tracks cursor and configuration, turns each accepted command into the bus
  // writes it should produce, and checks the written beats against them.
  class lcd_bus_tracker;
    logic        eight_bit;
    logic [15:0] long_wait;
    logic [15:0] short_wait;
    logic [15:0] data_wait;
    int unsigned cur_col;
    int unsigned cur_line;
    bus_write_t  pending_writes[$];
    int unsigned mismatch_count;

    function new();
      eight_bit      = 1'b0;
      long_wait      = RstLongWait;
      short_wait     = RstShortWait;
      data_wait      = RstDataWait;
      cur_col        = 0;
      cur_line       = 0;
      mismatch_count = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [15:0] value);
      case (idx)
        REG_EIGHT_BIT:  eight_bit  = value[0];
        REG_LONG_WAIT:  long_wait  = value;
        REG_SHORT_WAIT: short_wait = value;
        default:        data_wait  = value;
      endcase
    endfunction

    function void push_write(logic rs, logic [7:0] b, logic [15:0] w);
      bus_write_t bw;
      bw.rs       = rs;
      bw.bus_byte = b;
      bw.wait_us  = w;
      bw.last     = 1'b0;
      pending_writes.push_back(bw);
    endfunction

    // A byte goes out whole in 8-bit mode, else as high then low nibble.
    function void send_byte(logic rs, logic [7:0] b, logic [15:0] w);
      if (eight_bit) begin
        push_write(rs, b, w);
      end else begin
        push_write(rs, b & HighNibMask, 16'd0);
        push_write(rs, {b[3:0], 4'h0}, w);
      end
    endfunction

    // Bytes up to 0x01 (clear) take the long wait, all others the short wait.
    function void send_cmd(logic [7:0] c);
      send_byte(1'b0, c, (c <= CmdClear) ? long_wait : short_wait);
    endfunction

    // Lines past the last one map to address zero.
    function void set_address(logic [7:0] col, int unsigned ln);
      logic [7:0] base;
      case (ln)
        1:       base = 8'h40;
        2:       base = 8'h14;
        3:       base = 8'h54;
        default: base = 8'h00;
      endcase
      if (ln >= TbLines) base = 8'h00;
      send_cmd(((base + col) & AddrMask) | CmdSetAddr);
    endfunction

    function void clear_display();
      send_cmd(CmdClear);
      send_cmd(CmdSetAddr);
      cur_col  = 0;
      cur_line = 0;
    endfunction

    function void note_command(cmd_e cmd, logic [4:0] col, logic [1:0] ln, logic [7:0] ch);
      int unsigned first;
      bus_write_t  tail;
      first = pending_writes.size();
      case (cmd)
        CMD_INIT: begin
          if (eight_bit) begin
            send_cmd(CmdFunc8);
          end else begin
            push_write(1'b0, CmdFunc4Nib, 16'd0);
            send_cmd(CmdFunc4);
          end
          send_cmd(CmdDispOff);
          send_cmd(CmdClear);
          send_cmd(CmdEntryMode);
          send_cmd(CmdHome);
          send_cmd(CmdDispOn);
          send_cmd(CmdSetAddr);
          clear_display();
        end
        CMD_GOTO: begin
          cur_col  = (col > TbColumns - 1) ? TbColumns - 1 : col;
          cur_line = (ln > TbLines - 1) ? TbLines - 1 : ln;
          set_address(8'(cur_col), cur_line);
        end
        CMD_CHAR: begin
          send_byte(1'b1, ch, data_wait);
          cur_col++;
          if (cur_col >= TbColumns) begin
            cur_col = 0;
            cur_line++;
            set_address(8'h00, cur_line);
            // Wrapping off the last line sends the home address twice.
            if (cur_line >= TbLines) begin
              cur_line = 0;
              set_address(8'h00, 0);
            end
          end
        end
        default: clear_display();
      endcase
      if (pending_writes.size() > first) begin
        tail      = pending_writes.pop_back();
        tail.last = 1'b1;
        pending_writes.push_back(tail);
      end
    endfunction

    function void check_write(logic rs, logic [7:0] b, logic [15:0] w, logic last);
      bus_write_t exp;
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected bus write: expected none, actual rs=%0b byte=%h wait=%0d last=%0b",
                 $time, rs, b, w, last);
        mismatch_count++;
        return;
      end
      exp = pending_writes.pop_front();
      if (rs !== exp.rs) begin
        $display("%0t: register_select expected %0b actual %0b", $time, exp.rs, rs);
        mismatch_count++;
      end
      if (b !== exp.bus_byte) begin
        $display("%0t: bus_byte expected %h actual %h", $time, exp.bus_byte, b);
        mismatch_count++;
      end
      if (w !== exp.wait_us) begin
        $display("%0t: wait_us expected %0d actual %0d", $time, exp.wait_us, w);
        mismatch_count++;
      end
      if (last !== exp.last) begin
        $display("%0t: last expected %0b actual %0b", $time, exp.last, last);
        mismatch_count++;
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = REG_EIGHT_BIT;
  logic [15:0] cfg_data_i  = 16'd0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i   = CMD_INIT;
  logic [4:0]  column_i    = 5'd0;
  logic [1:0]  line_i      = 2'd0;
  logic [7:0]  character_i = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        register_select_o;
  logic [7:0]  bus_byte_o;
  logic [15:0] wait_us_o;
  logic        last_o;

  lcd_bus_tracker bus_model = new();

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit long_hold_req = 1'b0;
  int unsigned cycle_count = 0;

  char_lcd_cursor_writer #(
    .COLUMNS(TbColumns),
    .LINES  (TbLines)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .column_i         (column_i),
    .line_i           (line_i),
    .character_i      (character_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .register_select_o(register_select_o),
    .bus_byte_o       (bus_byte_o),
    .wait_us_o        (wait_us_o),
    .last_o           (last_o)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Run length guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Check every bus write beat the block hands over.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      bus_model.check_write(register_select_o, bus_byte_o, wait_us_o, last_o);
    end
  end

  // Receiver: random stall bursts, a long hold-off on request, none when disabled.
  initial begin
    int unsigned span;
    forever begin
      if (long_hold_req) begin
        out_stall_i   <= 1'b1;
        span          = LongHoldLen;
        long_hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        span        = $urandom_range(1, 18);
      end else begin
        out_stall_i <= 1'b0;
        span        = $urandom_range(1, 18);
      end
      repeat (span) @(negedge clk_i);
    end
  end

  // Offer one command beat and wait until it is taken; returns on a falling edge.
  task automatic send_command(cmd_e cmd, logic [4:0] col, logic [1:0] ln, logic [7:0] ch);
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    column_i    <= col;
    line_i      <= ln;
    character_i <= ch;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    bus_model.note_command(cmd, col, ln, ch);
    @(negedge clk_i);
  endtask

  task automatic idle_input(int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Stop offering and wait until every expected write has arrived.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (bus_model.pending_writes.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    bus_model.set_reg(idx, value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(logic mode, logic [15:0] lw, logic [15:0] sw, logic [15:0] dw);
    write_reg(REG_EIGHT_BIT, {15'd0, mode});
    write_reg(REG_LONG_WAIT, lw);
    write_reg(REG_SHORT_WAIT, sw);
    write_reg(REG_DATA_WAIT, dw);
  endtask

  // Mostly character writes and gotos near the line end so wraps come often.
  task automatic random_commands(int unsigned n, bit gaps);
    int unsigned pick;
    cmd_e        cmd;
    logic [4:0]  col;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 58)      cmd = CMD_CHAR;
      else if (pick < 83) cmd = CMD_GOTO;
      else if (pick < 94) cmd = CMD_CLEAR;
      else                cmd = CMD_INIT;
      col = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(14, 19));
      send_command(cmd, col, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      if (gaps && tx_idle_on && $urandom_range(0, 3) == 0) idle_input($urandom_range(1, 18));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part on the reset configuration: 4-bit bus.
    send_command(CMD_INIT, 5'd0, 2'd0, 8'h00);
    send_command(CMD_CHAR, 5'd0, 2'd0, 8'h41);
    send_command(CMD_CHAR, 5'd31, 2'd3, 8'hFF);
    send_command(CMD_CHAR, 5'd0, 2'd0, 8'h00);
    // Clamped goto, then a wrap off the last line.
    send_command(CMD_GOTO, 5'd31, 2'd3, 8'h00);
    send_command(CMD_CHAR, 5'd0, 2'd0, 8'h5A);
    // Column wraps into each following line.
    send_command(CMD_GOTO, 5'd19, 2'd0, 8'h00);
    send_command(CMD_CHAR, 5'd0, 2'd0, 8'h30);
    send_command(CMD_GOTO, 5'd19, 2'd1, 8'h00);
    send_command(CMD_CHAR, 5'd0, 2'd0, 8'h31);
    send_command(CMD_GOTO, 5'd19, 2'd2, 8'h00);
    send_command(CMD_CHAR, 5'd0, 2'd0, 8'h32);
    send_command(CMD_GOTO, 5'd0, 2'd0, 8'h00);
    send_command(CMD_GOTO, 5'd20, 2'd2, 8'h00);
    send_command(CMD_CLEAR, 5'd0, 2'd0, 8'h00);
    drain();

    // Directed part on an 8-bit bus with zero waits.
    configure(1'b1, 16'd0, 16'd0, 16'd0);
    send_command(CMD_INIT, 5'd0, 2'd0, 8'h00);
    send_command(CMD_GOTO, 5'd19, 2'd3, 8'h00);
    send_command(CMD_CHAR, 5'd0, 2'd0, 8'hA5);
    send_command(CMD_CLEAR, 5'd0, 2'd0, 8'h00);
    send_command(CMD_CHAR, 5'd0, 2'd0, 8'h5A);
    drain();

    // Maximum waits on a 4-bit bus.
    configure(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_command(CMD_INIT, 5'd0, 2'd0, 8'h00);
    send_command(CMD_GOTO, 5'd5, 2'd1, 8'h00);
    send_command(CMD_CHAR, 5'd0, 2'd0, 8'hC3);
    drain();

    // Random commands with idling on both sides.
    configure(1'b0, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)));
    random_commands(50, 1'b1);
    drain();

    // Long receiver hold-off while commands keep coming, then random traffic.
    configure(1'b1, 16'hFFFF, 16'd0, 16'hFFFF);
    long_hold_req = 1'b1;
    random_commands(14, 1'b0);
    random_commands(36, 1'b1);
    drain();

    configure(1'b0, RstLongWait, RstShortWait, RstDataWait);
    random_commands(50, 1'b1);
    drain();

    // Final stretch with no idling on either side.
    configure(1'b1, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_commands(50, 1'b0);
    drain();
    repeat (20) @(posedge clk_i);

    if (bus_model.mismatch_count == 0 && bus_model.pending_writes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/clw_pkg.sv
src/clw_emitter.sv
src/char_lcd_cursor_writer.sv
tb/char_lcd_cursor_writer_tb.sv
